FILE: hw/rtl/pqtf_pkg.sv
// Shared constants and widths for the Poisson quantile table fill block.
`timescale 1ns / 1ps
package pqtf_pkg;

	localparam int MAX_TABLE_SIZE = 64;
	localparam int SIZE_W         = 7;
	localparam int MEAN_W         = 24;
	localparam int PROB_W         = 32;
	localparam int CUM_W          = 34;
	localparam int INDEX_W        = 6;
	localparam int COUNT_W        = 6;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(10);
	localparam logic [SIZE_W-1:0]  SIZE_MAX   = SIZE_W'(MAX_TABLE_SIZE);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

	// shared multiplier: cumulative x size, and probability x mean
	localparam int MUL_A_W = CUM_W;
	localparam int MUL_B_W = MEAN_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// divider: (prob * mu) >> 16 divided by count, four quotient bits a cycle
	localparam int FRAC_SHIFT = 16;
	localparam int DIVIDEND_W = PROB_W + MEAN_W - FRAC_SHIFT;
	localparam int DIGIT_W    = 4;
	localparam int DIV_STEPS  = DIVIDEND_W / DIGIT_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

endpackage

FILE: hw/rtl/poisson_quantile_table_fill_top.sv
// Top level: sequencer and state for the Poisson quantile table fill.
`timescale 1ns / 1ps
// A request (start while busy is low) carries the mean mu (Q8.16) and exp(-mu)
// (Q0.32) and yields table_size entries (zero taken as one, above 64 as 64),
// one strobe cycle each, in index order; last_entry marks the final one. The
// receiver cannot stall: each entry is on the ports for exactly one cycle. An
// entry whose count holds needs only the comparison; one whose count advances
// uses the shared multiplier twice, and the radix-16 divider needs ten iterations
// for the 40-bit quotient. Busy is high throughout a table. table_size is written
// only while busy is low: this binds the user, and the block does not enforce it.
module poisson_quantile_table_fill_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pqtf_pkg::SIZE_W-1:0]         cfg_wr_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [pqtf_pkg::MEAN_W-1:0]         mean_value,
	input  logic [pqtf_pkg::PROB_W-1:0]         exp_neg_mean,
	output logic                                strobe,
	output logic [pqtf_pkg::INDEX_W-1:0]        entry_index,
	output logic [pqtf_pkg::COUNT_W-1:0]        count_value,
	output logic                                last_entry
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_CMP_CHK,
		S_PMUL,
		S_DSTART,
		S_DIV
	} state_t;

	localparam logic [pqtf_pkg::CUM_W-1:0] CUM_MAX = {pqtf_pkg::CUM_W{1'b1}};

	state_t                          state_q;
	logic [pqtf_pkg::SIZE_W-1:0]     table_size_q;
	logic [pqtf_pkg::SIZE_W-1:0]     size_q;
	logic [pqtf_pkg::INDEX_W-1:0]    idx_q;
	logic [pqtf_pkg::COUNT_W-1:0]    count_q;
	logic [pqtf_pkg::MEAN_W-1:0]     mu_q;
	logic [pqtf_pkg::PROB_W-1:0]     prob_q;
	logic [pqtf_pkg::CUM_W-1:0]      cum_q;
	logic                            strobe_q;
	logic [pqtf_pkg::INDEX_W-1:0]    entry_index_q;
	logic [pqtf_pkg::COUNT_W-1:0]    count_value_q;
	logic                            last_entry_q;

	logic [pqtf_pkg::MUL_A_W-1:0]    mul_a;
	logic [pqtf_pkg::MUL_B_W-1:0]    mul_b;
	logic [pqtf_pkg::MUL_P_W-1:0]    mul_p;
	logic                            div_start;
	logic [pqtf_pkg::DIVIDEND_W-1:0] div_q;
	logic                            div_done;

	logic [pqtf_pkg::SIZE_W-1:0]     eff_size;
	logic                            is_last;
	logic                            below;
	logic [pqtf_pkg::PROB_W-1:0]     prob_new;
	logic [pqtf_pkg::CUM_W:0]        cum_sum;

	// zero is taken as one, anything above the maximum as the maximum
	always_comb begin
		eff_size = table_size_q;
		if (table_size_q == '0)
			eff_size = pqtf_pkg::SIZE_W'(1);
		else if (table_size_q > pqtf_pkg::SIZE_MAX)
			eff_size = pqtf_pkg::SIZE_MAX;
	end

	assign is_last = (pqtf_pkg::SIZE_W'(idx_q) + 1'b1) == size_q;

	// cumulative * N < i * 2^32
	assign below = mul_p < (pqtf_pkg::MUL_P_W'(idx_q) << 32);

	assign prob_new = (div_q[pqtf_pkg::DIVIDEND_W-1:pqtf_pkg::PROB_W] != '0) ?
		{pqtf_pkg::PROB_W{1'b1}} : div_q[pqtf_pkg::PROB_W-1:0];
	assign cum_sum  = {1'b0, cum_q} + (pqtf_pkg::CUM_W + 1)'(prob_new);

	always_comb begin
		case (state_q)
			S_PMUL: begin
				mul_a = pqtf_pkg::MUL_A_W'(prob_q);
				mul_b = mu_q;
			end
			default: begin
				mul_a = cum_q;
				mul_b = pqtf_pkg::MUL_B_W'(size_q);
			end
		endcase
	end

	assign div_start = (state_q == S_DSTART);

	pqtf_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (mul_p)
	);

	pqtf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p[pqtf_pkg::FRAC_SHIFT+pqtf_pkg::DIVIDEND_W-1:pqtf_pkg::FRAC_SHIFT]),
		.divisor  (count_q),
		.quotient (div_q),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			table_size_q  <= pqtf_pkg::SIZE_RESET;
			strobe_q      <= 1'b0;
			mu_q          <= '0;
			prob_q        <= '0;
			cum_q         <= '0;
			size_q        <= '0;
			idx_q         <= '0;
			count_q       <= '0;
			entry_index_q <= '0;
			count_value_q <= '0;
			last_entry_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_wr_en)
				table_size_q <= cfg_wr_data;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						mu_q    <= mean_value;
						prob_q  <= exp_neg_mean;
						cum_q   <= pqtf_pkg::CUM_W'(exp_neg_mean);
						size_q  <= eff_size;
						idx_q   <= '0;
						count_q <= '0;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_CMP_CHK;
				end
				S_CMP_CHK: begin
					if (below) begin
						if (count_q != pqtf_pkg::COUNT_MAX)
							count_q <= count_q + 1'b1;
						state_q <= S_PMUL;
					end else begin
						strobe_q      <= 1'b1;
						entry_index_q <= idx_q;
						count_value_q <= count_q;
						last_entry_q  <= is_last;
						idx_q         <= idx_q + 1'b1;
						state_q       <= is_last ? S_IDLE : S_CMP;
					end
				end
				S_PMUL: begin
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						prob_q        <= prob_new;
						cum_q         <= cum_sum[pqtf_pkg::CUM_W] ? CUM_MAX :
							cum_sum[pqtf_pkg::CUM_W-1:0];
						strobe_q      <= 1'b1;
						entry_index_q <= idx_q;
						count_value_q <= count_q;
						last_entry_q  <= is_last;
						idx_q         <= idx_q + 1'b1;
						state_q       <= is_last ? S_IDLE : S_CMP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign strobe      = strobe_q;
	assign entry_index = entry_index_q;
	assign count_value = count_value_q;
	assign last_entry  = last_entry_q;

endmodule

FILE: hw/rtl/pqtf_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module pqtf_mul (
	input  logic                         clk,
	input  logic [pqtf_pkg::MUL_A_W-1:0] op_a,
	input  logic [pqtf_pkg::MUL_B_W-1:0] op_b,
	output logic [pqtf_pkg::MUL_P_W-1:0] product
);

	logic [pqtf_pkg::MUL_P_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= pqtf_pkg::MUL_P_W'(op_a) * pqtf_pkg::MUL_P_W'(op_b);
	end

	assign product = product_q;

endmodule

FILE: hw/rtl/pqtf_div.sv
// Iterative restoring divider, radix 16, for the probability update.
`timescale 1ns / 1ps
module pqtf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pqtf_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [pqtf_pkg::COUNT_W-1:0]    divisor,
	output logic [pqtf_pkg::DIVIDEND_W-1:0] quotient,
	output logic                            done
);

	localparam logic [pqtf_pkg::STEP_W-1:0] LAST_STEP =
		pqtf_pkg::STEP_W'(pqtf_pkg::DIV_STEPS - 1);

	// work_q shifts dividend bits out at the top and quotient bits in at the bottom
	logic [pqtf_pkg::DIVIDEND_W-1:0] work_q;
	logic [pqtf_pkg::COUNT_W-1:0]    rem_q;
	logic [pqtf_pkg::COUNT_W-1:0]    div_q;
	logic [pqtf_pkg::STEP_W-1:0]     step_q;
	logic                            run_q;
	logic                            done_q;

	logic [pqtf_pkg::COUNT_W-1:0]    rem_d;
	logic [pqtf_pkg::DIGIT_W-1:0]    digit_d;

	always_comb begin
		logic [pqtf_pkg::COUNT_W:0] trial;
		rem_d   = rem_q;
		digit_d = '0;
		for (int k = 0; k < pqtf_pkg::DIGIT_W; k++) begin
			trial = {rem_d, work_q[pqtf_pkg::DIVIDEND_W-1-k]};
			if (trial >= {1'b0, div_q}) begin
				rem_d = pqtf_pkg::COUNT_W'(trial - {1'b0, div_q});
				digit_d[pqtf_pkg::DIGIT_W-1-k] = 1'b1;
			end else begin
				rem_d = trial[pqtf_pkg::COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (run_q) begin
			work_q <= {work_q[pqtf_pkg::DIVIDEND_W-pqtf_pkg::DIGIT_W-1:0], digit_d};
			rem_q  <= rem_d;
		end
	end

	assign quotient = work_q;
	assign done     = done_q;

endmodule

FILE: bench/poisson_quantile_table_fill_top_tb.sv
// Self-checking bench for the Poisson quantile table fill block.
`timescale 1ns / 1ps
module poisson_quantile_table_fill_top_tb;

	typedef struct packed {
		logic [pqtf_pkg::INDEX_W-1:0] index;
		logic [pqtf_pkg::COUNT_W-1:0] count;
		logic                         last;
	} table_entry_t;

	typedef struct packed {
		logic [pqtf_pkg::MEAN_W-1:0] mean;
		logic [pqtf_pkg::PROB_W-1:0] expv;
	} quantile_req_t;

	localparam logic [63:0] CUM_LIMIT  = (64'd1 << pqtf_pkg::CUM_W) - 64'd1;
	localparam logic [63:0] PROB_LIMIT = 64'hFFFF_FFFF;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [pqtf_pkg::SIZE_W-1:0]   cfg_wr_data = '0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [pqtf_pkg::MEAN_W-1:0]   mean_value = '0;
	logic [pqtf_pkg::PROB_W-1:0]   exp_neg_mean = '0;
	logic                          strobe;
	logic [pqtf_pkg::INDEX_W-1:0]  entry_index;
	logic [pqtf_pkg::COUNT_W-1:0]  count_value;
	logic                          last_entry;

	quantile_req_t pending_reqs[$];
	table_entry_t  entries_due[$];
	logic [pqtf_pkg::SIZE_W-1:0] size_shadow = pqtf_pkg::SIZE_RESET;
	int unsigned   reqs_sent = 0;
	int unsigned   reqs_taken = 0;
	int unsigned   mismatches = 0;
	int            gap_left = 0;
	bit            no_idle = 1'b0;

	poisson_quantile_table_fill_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.busy         (busy),
		.mean_value   (mean_value),
		.exp_neg_mean (exp_neg_mean),
		.strobe       (strobe),
		.entry_index  (entry_index),
		.count_value  (count_value),
		.last_entry   (last_entry)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("poisson_quantile_table_fill_top regression: fail");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Expected table for one request, appended to entries_due
	function automatic void predict_table(input logic [pqtf_pkg::MEAN_W-1:0] mu,
			input logic [pqtf_pkg::PROB_W-1:0] e0);
		logic [63:0] n;
		logic [63:0] prob;
		logic [63:0] cum;
		logic [63:0] count;
		logic [63:0] quot;
		table_entry_t ent;
		n = 64'(size_shadow);
		if (n == 0)
			n = 1;
		if (n > pqtf_pkg::MAX_TABLE_SIZE)
			n = pqtf_pkg::MAX_TABLE_SIZE;
		prob = 64'(e0);
		cum = 64'(e0);
		count = 0;
		for (int i = 0; i < n; i++) begin
			// exact test of cum * N < i against the Q2.32 scale
			if (cum * n < (64'(i) << 32)) begin
				if (count < pqtf_pkg::COUNT_MAX)
					count++;
				quot = (prob * 64'(mu)) / (count << pqtf_pkg::FRAC_SHIFT);
				prob = (quot > PROB_LIMIT) ? PROB_LIMIT : quot;
				cum = cum + prob;
				if (cum > CUM_LIMIT)
					cum = CUM_LIMIT;
			end
			ent.index = pqtf_pkg::INDEX_W'(i);
			ent.count = count[pqtf_pkg::COUNT_W-1:0];
			ent.last = (i + 1 == n);
			entries_due = {entries_due, ent};
		end
	endfunction

	// exp(-mu) in Q0.32 by a short series on mu/256, squared eight times
	function automatic logic [pqtf_pkg::PROB_W-1:0] approx_exp_neg(
			input logic [pqtf_pkg::MEAN_W-1:0] mu);
		real x;
		real e;
		x = mu;
		x = x / 65536.0 / 256.0;
		e = 1.0 - x + x * x / 2.0 - x * x * x / 6.0;
		for (int k = 0; k < 8; k++)
			e = e * e;
		if (e >= 1.0)
			return '1;
		return pqtf_pkg::PROB_W'(longint'(e * 4294967296.0));
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	always @(negedge clk) begin : request_driver
		quantile_req_t req;
		if (arst_n && reqs_sent == reqs_taken) begin
			if (gap_left > 0 || pending_reqs.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				start <= 1'b0;
				mean_value <= pqtf_pkg::MEAN_W'($urandom);
				exp_neg_mean <= $urandom;
			end else begin
				req = pending_reqs.pop_front();
				start <= 1'b1;
				mean_value <= req.mean;
				exp_neg_mean <= req.expv;
				reqs_sent++;
				gap_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : entry_monitor
		table_entry_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				size_shadow = cfg_wr_data;
			if (start && !busy) begin
				predict_table(mean_value, exp_neg_mean);
				reqs_taken++;
			end
			if (strobe) begin
				if (entries_due.size() == 0) begin
					flag_mismatch("unexpected entry, index", '0, 32'(entry_index));
				end else begin
					want = entries_due.pop_front();
					if (entry_index !== want.index)
						flag_mismatch("entry_index", 32'(want.index), 32'(entry_index));
					if (count_value !== want.count)
						flag_mismatch("count_value", 32'(want.count), 32'(count_value));
					if (last_entry !== want.last)
						flag_mismatch("last_entry", 32'(want.last), 32'(last_entry));
				end
			end
		end
	end

	task automatic wait_until_idle();
		while (!(pending_reqs.size() == 0 && reqs_sent == reqs_taken
				&& entries_due.size() == 0 && busy === 1'b0))
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_table_size(input logic [pqtf_pkg::SIZE_W-1:0] v);
		wait_until_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= pqtf_pkg::SIZE_W'($urandom);
		@(posedge clk);
	endtask

	task automatic queue_req(input logic [pqtf_pkg::MEAN_W-1:0] mu,
			input logic [pqtf_pkg::PROB_W-1:0] e0);
		quantile_req_t req;
		req.mean = mu;
		req.expv = e0;
		pending_reqs = {pending_reqs, req};
	endtask

	// mostly plausible (mu, exp(-mu)) pairs with a little jitter, the rest raw noise
	task automatic queue_random_req();
		logic [pqtf_pkg::MEAN_W-1:0] mu;
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			queue_req(pqtf_pkg::MEAN_W'($urandom), $urandom);
		end else begin
			if (r < 70)
				mu = pqtf_pkg::MEAN_W'($urandom_range(0, 12 << 16));
			else if (r < 92)
				mu = pqtf_pkg::MEAN_W'($urandom_range(0, 40 << 16));
			else
				mu = pqtf_pkg::MEAN_W'($urandom);
			queue_req(mu, approx_exp_neg(mu) ^ pqtf_pkg::PROB_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int r;
		int drain;
		logic [pqtf_pkg::SIZE_W-1:0] sz;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset table size, field extremes and a few typical means
		queue_req('0, '0);
		queue_req('1, '1);
		queue_req('1, '0);
		queue_req('0, '1);
		queue_req(pqtf_pkg::MEAN_W'(1 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(1 << 16)));
		queue_req(pqtf_pkg::MEAN_W'(4 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(4 << 16)));
		queue_req(pqtf_pkg::MEAN_W'(1 << 16), 32'h8000_0000);

		// largest table: count runs up to its ceiling, probability saturates
		set_table_size(pqtf_pkg::SIZE_MAX);
		queue_req('0, '0);
		queue_req('1, 32'd1);
		queue_req(pqtf_pkg::MEAN_W'(8 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(8 << 16)));
		queue_req(pqtf_pkg::MEAN_W'(40 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(40 << 16)));

		// zero size behaves as one entry
		set_table_size('0);
		queue_req(24'h12_3456, 32'hABCD_EF01);
		queue_req('0, '0);

		// oversize values clamp to the maximum
		set_table_size('1);
		queue_req('0, '0);
		queue_req(pqtf_pkg::MEAN_W'(2 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(2 << 16)));
		set_table_size(pqtf_pkg::SIZE_W'(pqtf_pkg::MAX_TABLE_SIZE + 1));
		queue_req(pqtf_pkg::MEAN_W'(20 << 16), approx_exp_neg(pqtf_pkg::MEAN_W'(20 << 16)));

		set_table_size(pqtf_pkg::SIZE_W'(1));
		queue_req('0, '0);
		queue_req('1, '1);

		for (int ph = 0; ph < 12; ph++) begin
			r = $urandom_range(0, 99);
			if (ph == 0)
				sz = pqtf_pkg::SIZE_W'(pqtf_pkg::MAX_TABLE_SIZE - 1);
			else if (ph == 1)
				sz = pqtf_pkg::SIZE_W'(2);
			else if (r < 70)
				sz = pqtf_pkg::SIZE_W'($urandom_range(1, 16));
			else if (r < 85)
				sz = pqtf_pkg::SIZE_W'($urandom_range(17, pqtf_pkg::MAX_TABLE_SIZE));
			else
				sz = pqtf_pkg::SIZE_W'($urandom);
			set_table_size(sz);
			no_idle = ($urandom_range(0, 2) == 0);
			repeat (12) queue_random_req();
		end

		while (!(pending_reqs.size() == 0 && reqs_sent == reqs_taken))
			@(negedge clk);
		drain = 0;
		while (entries_due.size() != 0 && drain < 4000) begin
			@(negedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (entries_due.size() != 0)
			flag_mismatch("entries never produced", 32'(entries_due.size()), '0);

		if (mismatches == 0)
			$display("poisson_quantile_table_fill_top regression: pass");
		else
			$display("poisson_quantile_table_fill_top regression: fail");
		$finish;
	end

endmodule
